// ===== design/gcdl_pkg.sv =====
// ----------------------------------------------------------------------------
// gcdl_pkg
// Shared widths and operation codes for the integer gcd / lcm unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gcdl_pkg;

   localparam int OPND_W = 64;   // signed operand width
   localparam int RES_W  = 63;   // nonnegative result width
   localparam int CNT_W  = 6;    // bit counter for the 64-step loops

   localparam logic OP_GCD = 1'b0;
   localparam logic OP_LCM = 1'b1;

endpackage : gcdl_pkg

`default_nettype wire

// ===== design/gcdl_ifs.sv =====
// ----------------------------------------------------------------------------
// gcdl_ifs
// Valid/ready channels for the gcd / lcm unit: request and response.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcdl_req_if;
   logic                               valid;
   logic                               ready;
   logic                               op;
   logic signed [gcdl_pkg::OPND_W-1:0] operand_a;
   logic signed [gcdl_pkg::OPND_W-1:0] operand_b;

   modport source (output valid, output op, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input op, input operand_a, input operand_b,
                   output ready);
endinterface : gcdl_req_if

interface gcdl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gcdl_pkg::RES_W-1:0]  result;
   logic                        overflow;

   modport source (output valid, output result, output overflow, input ready);
   modport sink   (input valid, input result, input overflow, output ready);
endinterface : gcdl_rsp_if

`default_nettype wire

// ===== design/integer_gcd_lcm_unit_core.sv =====
// ----------------------------------------------------------------------------
// integer_gcd_lcm_unit_core
// Gcd or lcm of two signed 64-bit integers with 63-bit saturated result.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake        payload
//   --------  ----  ---------------  ---------------------------------------
//   req_ch    in    valid / ready    op, operand_a, operand_b
//   rsp_ch    out   valid / ready    result, overflow (result saturated)
//
// Sequence: one transaction runs through a sequencer around a single 64-bit
// add/subtract unit: the magnitude of each operand, a check, up to 63 common
// halvings, the binary gcd loop (one subtract-and-halve, swap or halve per
// cycle), up to 63 rescale shifts, then for lcm 64 divide and 64 multiply
// steps. The next transaction can be accepted in the same cycle as the
// response is presented.
// Reset: synchronous, active high; clears the sequencer and response valid.
// Stalls: req_ch.ready is high only while idle. A finished response waits in
// the output register while the next transaction is accepted; a new result
// holds in the finish state until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_gcd_lcm_unit_core (
   input  wire        clock,
   input  wire        reset,
   gcdl_req_if.sink   req_ch,
   gcdl_rsp_if.source rsp_ch
);

   localparam int W = gcdl_pkg::OPND_W;
   localparam int R = gcdl_pkg::RES_W;
   localparam int C = gcdl_pkg::CNT_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAG_A,
      ST_MAG_B,
      ST_CHECK,
      ST_HALVE,
      ST_STEIN,
      ST_SCALE,
      ST_DIV,
      ST_MUL,
      ST_FINISH
   } state_type;

   state_type      state_ff, state_in;
   logic           op_ff, op_in;
   logic [W-1:0]   u_ff, u_in;     // gcd working value, dividend/quotient, multiplier
   logic [W-1:0]   v_ff, v_in;     // gcd working value, remainder, product
   logic [W-1:0]   a_ff, a_in;     // |operand_a|
   logic [W-1:0]   b_ff, b_in;     // |operand_b|
   logic [W-1:0]   g_ff, g_in;     // gcd, divisor for lcm
   logic [C-1:0]   k_ff, k_in;     // common power of two
   logic [C-1:0]   cnt_ff, cnt_in; // divide / multiply step counter
   logic           ovf_ff, ovf_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [R-1:0]   rsp_result_ff, rsp_result_in;
   logic           rsp_overflow_ff, rsp_overflow_in;

   // shared adder / subtractor
   logic [W-1:0]   alu_a, alu_b;
   logic           alu_sub;
   logic [W:0]     alu_sum;        // alu_sum[W]: carry, or no-borrow on subtract
   logic [W-1:0]   div_rem;        // partial remainder with next dividend bit

   assign div_rem = {v_ff[W-2:0], u_ff[W-1]};

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         ST_MAG_A: begin
            alu_b   = u_ff;
            alu_sub = 1'b1;
         end
         ST_MAG_B: begin
            alu_b   = v_ff;
            alu_sub = 1'b1;
         end
         ST_STEIN: begin
            alu_a   = v_ff;
            alu_b   = u_ff;
            alu_sub = 1'b1;
         end
         ST_DIV: begin
            alu_a   = div_rem;
            alu_b   = g_ff;
            alu_sub = 1'b1;
         end
         ST_MUL: begin
            alu_a   = {v_ff[W-2:0], 1'b0};
            alu_b   = u_ff[W-1] ? b_ff : '0;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {W{alu_sub}}} + (W+1)'(alu_sub);

   // sequencer next state
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      u_in            = u_ff;
      v_in            = v_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      g_in            = g_ff;
      k_in            = k_ff;
      cnt_in          = cnt_ff;
      ovf_in          = ovf_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_result_in   = rsp_result_ff;
      rsp_overflow_in = rsp_overflow_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.op;
               u_in     = req_ch.operand_a;
               v_in     = req_ch.operand_b;
               state_in = ST_MAG_A;
            end
         end
         ST_MAG_A: begin
            // take the magnitude; the most negative value maps to 2^63 exactly
            u_in     = u_ff[W-1] ? alu_sum[W-1:0] : u_ff;
            a_in     = u_ff[W-1] ? alu_sum[W-1:0] : u_ff;
            state_in = ST_MAG_B;
         end
         ST_MAG_B: begin
            v_in     = v_ff[W-1] ? alu_sum[W-1:0] : v_ff;
            b_in     = v_ff[W-1] ? alu_sum[W-1:0] : v_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            k_in = '0;
            if (u_ff == '0 || v_ff == '0) begin
               if (op_ff == gcdl_pkg::OP_LCM) begin
                  v_in     = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  u_in     = u_ff | v_ff;
                  state_in = ST_SCALE;
               end
            end else begin
               state_in = ST_HALVE;
            end
         end
         ST_HALVE: begin
            // strip common factors of two
            if (u_ff[0] || v_ff[0]) begin
               state_in = ST_STEIN;
            end else begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + C'(1);
            end
         end
         ST_STEIN: begin
            if (v_ff == '0) begin
               state_in = ST_SCALE;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!alu_sum[W]) begin
               // v < u: swap, subtract next cycle
               u_in = v_ff;
               v_in = u_ff;
            end else begin
               // both odd: difference is even, halve it at once
               v_in = {1'b0, alu_sum[W-1:1]};
            end
         end
         ST_SCALE: begin
            if (k_ff != '0) begin
               u_in = u_ff << 1;
               k_in = k_ff - C'(1);
            end else if (op_ff == gcdl_pkg::OP_GCD) begin
               v_in     = u_ff;
               ovf_in   = u_ff[W-1];
               state_in = ST_FINISH;
            end else begin
               g_in     = u_ff;
               u_in     = a_ff;
               v_in     = '0;
               cnt_in   = '1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring division |a| / gcd, one quotient bit per cycle
            u_in   = {u_ff[W-2:0], alu_sum[W]};
            v_in   = alu_sum[W] ? alu_sum[W-1:0] : div_rem;
            cnt_in = cnt_ff - C'(1);
            if (cnt_ff == '0) begin
               v_in     = '0;
               ovf_in   = 1'b0;
               cnt_in   = '1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // MSB-first shift-add; the partial product never shrinks, so any
            // excursion past 63 bits is sticky overflow
            v_in   = alu_sum[W-1:0];
            ovf_in = ovf_ff | v_ff[W-1] | alu_sum[W] | alu_sum[W-1];
            u_in   = u_ff << 1;
            cnt_in = cnt_ff - C'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_result_in   = ovf_ff ? '1 : v_ff[R-1:0];
               rsp_overflow_in = ovf_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff           <= op_in;
      u_ff            <= u_in;
      v_ff            <= v_in;
      a_ff            <= a_in;
      b_ff            <= b_in;
      g_ff            <= g_in;
      k_ff            <= k_in;
      cnt_ff          <= cnt_in;
      ovf_ff          <= ovf_in;
      rsp_result_ff   <= rsp_result_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.result   = rsp_result_ff;
   assign rsp_ch.overflow = rsp_overflow_ff;

   // a saturated response always carries the all-ones result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_overflow_ff |-> rsp_result_ff == '1)
      else $error("overflow response without saturated result");

   // an accepted transaction starts with the magnitude step
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == ST_MAG_A)
      else $error("accepted transaction did not start the sequencer");

   // binary gcd loop keeps at least one odd working value
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEIN |-> (u_ff[0] || v_ff[0]))
      else $error("gcd loop lost its odd operand");

   // division remainder stays below the divisor, so below 2^63
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !v_ff[W-1])
      else $error("division remainder out of range");

   // no response right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

endmodule : integer_gcd_lcm_unit_core

`default_nettype wire

// ===== test/gcdl_check.sv =====
// ----------------------------------------------------------------------------
// gcdl_check
// Watches both channels of the gcd / lcm unit, predicts each response from
// the accepted request and compares the two fields in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcdl_check (
   input  wire  clock,
   input  wire  reset,
   gcdl_req_if  req_ch,
   gcdl_rsp_if  rsp_ch,
   output int   mismatch_count,
   output int   pending
);

   localparam logic [gcdl_pkg::OPND_W-1:0] RES_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [gcdl_pkg::RES_W-1:0] result;
      logic                       overflow;
   } outcome_type;

   outcome_type awaited_outcomes[$];

   // Exact magnitudes, Euclid for the divisor, a 128-bit product for the lcm.
   function automatic outcome_type predict_outcome(logic op,
                                                   logic [gcdl_pkg::OPND_W-1:0] a,
                                                   logic [gcdl_pkg::OPND_W-1:0] b);
      logic [gcdl_pkg::OPND_W-1:0]   ma, mb, u, v, t;
      logic [2*gcdl_pkg::OPND_W-1:0] prod;
      outcome_type                   o;
      ma = a[gcdl_pkg::OPND_W-1] ? ~a + 64'd1 : a;
      mb = b[gcdl_pkg::OPND_W-1] ? ~b + 64'd1 : b;
      u = ma;
      v = mb;
      while (v != 0) begin
         t = u % v;
         u = v;
         v = t;
      end
      o.overflow = 1'b0;
      o.result   = '0;
      if (op == gcdl_pkg::OP_GCD) begin
         if (u > RES_LIMIT) o.overflow = 1'b1;
         else o.result = u[gcdl_pkg::RES_W-1:0];
      end else if (ma != 0 && mb != 0) begin
         prod = {64'd0, ma / u} * {64'd0, mb};
         if (prod > {64'd0, RES_LIMIT}) o.overflow = 1'b1;
         else o.result = prod[gcdl_pkg::RES_W-1:0];
      end
      if (o.overflow) o.result = '1;
      return o;
   endfunction

   // Retire the response first: it can never belong to a request taken at
   // the same edge.
   always @(posedge clock) begin : compare
      outcome_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_outcomes.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: response with none awaited: result %h overflow %b",
                           $realtime, rsp_ch.result, rsp_ch.overflow);
               mismatch_count++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_ch.result !== want.result || rsp_ch.overflow !== want.overflow)
               begin
                  if (mismatch_count < 10)
                     $display("%0t: mismatch: result %h (want %h) overflow %b (want %b)",
                              $realtime, rsp_ch.result, want.result,
                              rsp_ch.overflow, want.overflow);
                  mismatch_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            awaited_outcomes.push_back(predict_outcome(req_ch.op, req_ch.operand_a,
                                                       req_ch.operand_b));
      end
      pending = awaited_outcomes.size();
   end

endmodule : gcdl_check

// ===== test/integer_gcd_lcm_unit_core_tb.sv =====
// ----------------------------------------------------------------------------
// integer_gcd_lcm_unit_core_tb
// Drives gcd and lcm requests into the unit: a directed set of corner cases
// (zeros, the most negative operand, saturating products), then random pairs
// of mixed widths and signs, some built on a shared factor. Both channels
// idle at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_gcd_lcm_unit_core_tb;

   localparam logic [gcdl_pkg::OPND_W-1:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [gcdl_pkg::OPND_W-1:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [gcdl_pkg::OPND_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [gcdl_pkg::OPND_W-1:0] BIT_62   = 64'h4000_0000_0000_0000;

   localparam int RANDOM_TXNS  = 900;
   localparam int HOLD_CYCLES  = 2000;   // long receiver hold-off
   localparam int SETTLE       = 400;    // settle time after the final drain
   localparam int STALL_LIMIT  = 20000;  // cycles without any transaction

   logic clock = 1'b0;
   logic reset;

   int   mismatch_count;
   int   pending;
   int   txn_sent;
   int   burst_left;
   int   quiet_cycles;

   gcdl_req_if req_ch ();
   gcdl_rsp_if rsp_ch ();

   integer_gcd_lcm_unit_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gcdl_check u_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Random operand: mostly narrow values of either sign, some full width,
   // some of the boundary values.
   function automatic logic [gcdl_pkg::OPND_W-1:0] rand_operand();
      logic [gcdl_pkg::OPND_W-1:0] v;
      int                          w;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0: v = '0;
               1: v = 64'd1;
               2: v = MAX_POS;
               3: v = MOST_NEG;
               default: v = ALL_ONES;
            endcase
         end
         1, 2: ;
         default: begin
            w = $urandom_range(1, 62);
            v = v & ((64'd1 << w) - 64'd1);
            if ($urandom_range(0, 1) != 0) v = ~v + 64'd1;
         end
      endcase
      return v;
   endfunction

   // Offer one transaction and hold it until the block takes it. A new
   // burst starts with a gap of random length, sometimes none at all.
   task automatic offer(input logic op, input logic [gcdl_pkg::OPND_W-1:0] a,
                        input logic [gcdl_pkg::OPND_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 8);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 8);
            6, 7:             gap = $urandom_range(9, 60);
            8:                gap = $urandom_range(61, 700);
            default:          gap = 0;
         endcase
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      do @(posedge clock); while (!req_ch.ready);
      txn_sent++;
   endtask

   // Drop valid and wait until every awaited response has come back. The
   // first edge lets the checker record the last accepted request.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   // Receiver: ready patterns of random length, from always ready to mostly
   // stalled. Once, after a few hundred requests, hold ready low long enough
   // for the output register to fill and the request channel to back up.
   initial begin : rsp_drain
      int mode;
      int len;
      bit held;
      rsp_ch.ready = 1'b0;
      held = 1'b0;
      wait (!reset);
      forever begin
         if (!held && txn_sent >= 300) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(1, 200);
         repeat (len) begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic                        op;
      logic [gcdl_pkg::OPND_W-1:0] a;
      logic [gcdl_pkg::OPND_W-1:0] b;
      logic [gcdl_pkg::OPND_W-1:0] k;
      int                          n;

      // Hold every input at a known value before the first edge.
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.op        = gcdl_pkg::OP_GCD;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      txn_sent         = 0;
      burst_left       = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Zeros: gcd falls back to the other magnitude, lcm is zero.
      offer(gcdl_pkg::OP_GCD, '0, '0);
      offer(gcdl_pkg::OP_GCD, '0, -64'sd15);
      offer(gcdl_pkg::OP_GCD, 64'd21, '0);
      offer(gcdl_pkg::OP_LCM, '0, '0);
      offer(gcdl_pkg::OP_LCM, '0, 64'd7);
      offer(gcdl_pkg::OP_LCM, MOST_NEG, '0);
      // Most negative operand: its magnitude 2^63 saturates a gcd.
      offer(gcdl_pkg::OP_GCD, MOST_NEG, '0);
      offer(gcdl_pkg::OP_GCD, MOST_NEG, MOST_NEG);
      offer(gcdl_pkg::OP_GCD, MOST_NEG, 64'd3);
      offer(gcdl_pkg::OP_GCD, MOST_NEG, BIT_62);
      offer(gcdl_pkg::OP_GCD, MAX_POS, MOST_NEG);
      offer(gcdl_pkg::OP_GCD, MAX_POS, MAX_POS);
      offer(gcdl_pkg::OP_GCD, ALL_ONES, ALL_ONES);
      offer(gcdl_pkg::OP_GCD, -64'sd12, 64'd18);
      // Lcm: small signed cases, exact fits and saturating products.
      offer(gcdl_pkg::OP_LCM, -64'sd4, 64'd6);
      offer(gcdl_pkg::OP_LCM, ALL_ONES, ALL_ONES);
      offer(gcdl_pkg::OP_LCM, MOST_NEG, 64'd1);
      offer(gcdl_pkg::OP_LCM, MOST_NEG, MOST_NEG);
      offer(gcdl_pkg::OP_LCM, MAX_POS, ALL_ONES);
      offer(gcdl_pkg::OP_LCM, MAX_POS, 64'd2);
      offer(gcdl_pkg::OP_LCM, BIT_62, 64'd2);
      offer(gcdl_pkg::OP_LCM, BIT_62, 64'd3);
      offer(gcdl_pkg::OP_LCM, 64'd2147483647, -64'sd2147483649);

      for (n = 0; n < RANDOM_TXNS; n++) begin
         // Once mid-run, let the block run completely dry.
         if (n == 600) drain_results();
         op = ($urandom_range(0, 1) != 0) ? gcdl_pkg::OP_LCM : gcdl_pkg::OP_GCD;
         if ($urandom_range(0, 3) == 0) begin
            // Shared factor: nontrivial divisors, and lcm values that often fit.
            k = {$urandom, $urandom} & ((64'd1 << $urandom_range(1, 40)) - 64'd1);
            a = k * ({$urandom, $urandom} & ((64'd1 << $urandom_range(1, 20)) - 64'd1));
            b = k * ({$urandom, $urandom} & ((64'd1 << $urandom_range(1, 20)) - 64'd1));
            if ($urandom_range(0, 1) != 0) a = ~a + 64'd1;
            if ($urandom_range(0, 1) != 0) b = ~b + 64'd1;
         end else begin
            a = rand_operand();
            b = rand_operand();
         end
         offer(op, a, b);
      end

      // Wait for the last responses, then leave room for anything stray.
      drain_results();
      repeat (SETTLE) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule : integer_gcd_lcm_unit_core_tb

// ===== integer_gcd_lcm_unit_core.f =====
design/gcdl_pkg.sv
design/gcdl_ifs.sv
design/integer_gcd_lcm_unit_core.sv
test/gcdl_check.sv
test/integer_gcd_lcm_unit_core_tb.sv
